// ===== design/adc_scan_averager_defines.svh =====
// Assertion macros used by the ADC scan averager top level.
// Needs a clock named clk and a synchronous active-high reset named rst in scope.
`ifndef ADC_SCAN_AVERAGER_DEFINES_SVH
`define ADC_SCAN_AVERAGER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/asa_pkg.sv =====
// Package for the ADC scan averager: sizes, configuration register indexes,
// and the request and result payload structs. It depends on nothing else.
package asa_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int SAMPLE_BITS = 10;
  localparam int MAX_SHIFT   = 8;

  localparam int SLOT_W  = $clog2(NUM_SLOTS);
  localparam int CNT_W   = 4;
  localparam int MUX_W   = 4;
  localparam int SHIFT_W = 4;
  localparam int MAP_W   = 32;
  localparam int ACC_W   = SAMPLE_BITS + MAX_SHIFT;
  localparam int COUNT_W = MAX_SHIFT + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
  localparam logic [COUNT_W-1:0]     COUNT_MAX  = COUNT_W'(1 << MAX_SHIFT);

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_SHIFT     = 2'd2;

  localparam logic ACTION_SAMPLE = 1'b0;
  localparam logic ACTION_READ   = 1'b1;

  typedef struct packed {
    logic                   action;
    logic [SAMPLE_BITS-1:0] sample;
    logic [3:0]             read_slot;
  } req_t;

  typedef struct packed {
    logic [MUX_W-1:0]       mux_select;
    logic                   average_written;
    logic [2:0]             average_slot;
    logic [SAMPLE_BITS-1:0] average_value;
    logic [SAMPLE_BITS-1:0] read_data;
  } res_t;

endpackage

// ===== design/adc_scan_averager.sv =====
// ADC scan averager top level; uses asa_pkg and adc_scan_averager_defines.svh.
// Results are registered. One request per cycle while req_stall is low; the only loop
// is the accumulator and slot update. A two-entry output stage (result register plus
// skid register) lets requests flow while one result waits. Synchronous active-high
// reset clears the scan state, the table and the valid flags.
`include "adc_scan_averager_defines.svh"

module adc_scan_averager (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [asa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [asa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  asa_pkg::req_t                       req_data,
  output logic                                res_valid,
  input  logic                                res_stall,
  output asa_pkg::res_t                       res_data
);
  import asa_pkg::*;

  // Configuration registers, held raw; clamping happens where they are used.
  logic [CNT_W-1:0]   channel_count;
  logic [MAP_W-1:0]   channel_map;
  logic [SHIFT_W-1:0] avg_shift;

  // Scan and averaging state.
  logic [ACC_W-1:0]       accumulator;
  logic [COUNT_W-1:0]     sample_count;
  logic [SLOT_W-1:0]      current_slot;
  logic [SAMPLE_BITS-1:0] slot_averages [NUM_SLOTS];

  // Output stage: the result register and a skid register behind it.
  res_t skid_data;
  logic skid_valid;

  logic accept;
  logic out_free;
  logic done;
  logic [CNT_W-1:0]       eff_count;
  logic [SHIFT_W-1:0]     eff_shift;
  logic [ACC_W-1:0]       acc_sum;
  logic [COUNT_W-1:0]     count_inc;
  logic [ACC_W-1:0]       acc_shifted;
  logic [SAMPLE_BITS-1:0] avg_value;
  logic [ACC_W-1:0]       accumulator_next;
  logic [COUNT_W-1:0]     sample_count_next;
  logic [SLOT_W-1:0]      current_slot_next;
  res_t                   result;

  // The request side stalls only while the skid register is occupied, which is
  // a registered condition, so stall never depends on the incoming valid.
  assign req_stall = skid_valid;
  assign accept    = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // Channel count 0 is treated as one slot, counts above the table size as the
  // full table. The shift saturates at eight, that is 256 samples per average.
  always_comb begin
    if (channel_count == '0) begin
      eff_count = CNT_W'(1);
    end else if (channel_count > CNT_W'(NUM_SLOTS)) begin
      eff_count = CNT_W'(NUM_SLOTS);
    end else begin
      eff_count = channel_count;
    end
    eff_shift = (avg_shift > SHIFT_W'(MAX_SHIFT)) ? SHIFT_W'(MAX_SHIFT) : avg_shift;
  end

  // One pass of the averaging step. The count never passes 256, since it is
  // cleared as soon as it reaches the current threshold, and a lowered shift
  // only makes that threshold come sooner. The accumulator is therefore bounded
  // by 256 full-scale samples and fits without overflow.
  always_comb begin
    acc_sum     = accumulator + ACC_W'(req_data.sample);
    count_inc   = sample_count + COUNT_W'(1);
    done        = count_inc >= (COUNT_W'(1) << eff_shift);
    acc_shifted = acc_sum >> eff_shift;
    // A shift lowered in the middle of an average can leave more than a full
    // scale in the shifted sum, so the stored value saturates.
    if (acc_shifted > ACC_W'(SAMPLE_MAX)) begin
      avg_value = SAMPLE_MAX;
    end else begin
      avg_value = acc_shifted[SAMPLE_BITS-1:0];
    end

    accumulator_next  = accumulator;
    sample_count_next = sample_count;
    current_slot_next = current_slot;

    result                 = '0;
    if (req_data.action == ACTION_SAMPLE) begin
      if (done) begin
        accumulator_next  = '0;
        sample_count_next = '0;
        // Wrap also covers a slot left beyond a channel count that shrank.
        if ((CNT_W'(current_slot) + CNT_W'(1)) < eff_count) begin
          current_slot_next = current_slot + SLOT_W'(1);
        end else begin
          current_slot_next = '0;
        end
        result.average_written = 1'b1;
        result.average_slot    = 3'(current_slot);
        result.average_value   = avg_value;
      end else begin
        accumulator_next  = acc_sum;
        sample_count_next = count_inc;
      end
    end else begin
      // Slots at or above the effective count read as zero.
      if (CNT_W'(req_data.read_slot) < eff_count) begin
        result.read_data = slot_averages[req_data.read_slot[SLOT_W-1:0]];
      end
    end
    result.mux_select = channel_map[{current_slot_next, 2'b00} +: MUX_W];
  end

  // Configuration registers. Writes to the unused index are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CNT_W'(1);
      channel_map   <= '0;
      avg_shift     <= SHIFT_W'(2);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        REG_CHANNEL_MAP:   channel_map   <= cfg_data[MAP_W-1:0];
        REG_AVG_SHIFT:     avg_shift     <= cfg_data[SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Scan state and the average table, updated once per accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator  <= '0;
      sample_count <= '0;
      current_slot <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_averages[i] <= '0;
      end
    end else if (accept) begin
      accumulator  <= accumulator_next;
      sample_count <= sample_count_next;
      current_slot <= current_slot_next;
      if (req_data.action == ACTION_SAMPLE && done) begin
        slot_averages[current_slot] <= avg_value;
      end
    end
  end

  // Output stage. A new result goes straight to the result register when that
  // register is empty or being taken; otherwise it parks in the skid register,
  // which drains into the result register as soon as there is room.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_free) begin
          res_data   <= skid_data;
          res_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (accept) begin
        if (out_free) begin
          res_data  <= result;
          res_valid <= 1'b1;
        end else begin
          skid_data  <= result;
          skid_valid <= 1'b1;
        end
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  `ASA_ASSERT_NOW(a_skid_behind_out, skid_valid, res_valid, "skid register full while result register empty")
  `ASA_ASSERT_NOW(a_count_bound, 1'b1, sample_count <= COUNT_MAX, "sample count above 256")
  `ASA_ASSERT_NEXT(a_read_keeps_acc, accept && req_data.action == ACTION_READ, $stable(accumulator) && $stable(sample_count) && $stable(current_slot), "read request changed scan state")
  `ASA_ASSERT_NOW(a_no_avg_fields, res_valid && !res_data.average_written, res_data.average_value == '0 && res_data.average_slot == '0, "average fields set without a completed average")

endmodule

// ===== tb/sv/adc_scan_averager_test.sv =====
// Self-checking testbench for adc_scan_averager: directed and random sample and read
// requests, predicted by a behavioral model of the scan and compared field by field.
// Depends on asa_pkg and the adc_scan_averager design files; reads and writes no files.
module adc_scan_averager_test;
  import asa_pkg::*;

  // Generous limit for the hang guard that still ends a hung run quickly.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 118;
  localparam int HOLD_CYCLES   = 300;

  // Every block input starts at a known value before the first edge.
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CHANNEL_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req_data  = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_t                  res_data;

  adc_scan_averager dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the configuration registers, holding their reset values.
  logic [CNT_W-1:0]   count_reg = CNT_W'(1);
  logic [MAP_W-1:0]   map_reg   = '0;
  logic [SHIFT_W-1:0] shift_reg = SHIFT_W'(2);

  // Shadow copy of the scan state: running sum, samples taken toward the current
  // average, the slot being converted and the table of stored averages.
  int unsigned            sum_q    = 0;
  int unsigned            taken    = 0;
  int unsigned            slot_now = 0;
  logic [SAMPLE_BITS-1:0] avg_table [NUM_SLOTS] = '{default: '0};

  req_t req_backlog[$];         // requests waiting for the driver
  res_t scan_results_ahead[$];  // predicted results, oldest first

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned cycles       = 0;

  // Driver pacing: requests go out in bursts, most of them separated by idle gaps.
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  // Receiver pacing: a stall pattern that changes now and then, plus one long hold.
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;
  res_t        due_result;

  // Number of slots actually scanned: zero counts as one, and the count tops
  // out at the size of the table.
  function automatic int unsigned scan_width();
    if (count_reg == 0) return 1;
    if (count_reg > NUM_SLOTS) return NUM_SLOTS;
    return count_reg;
  endfunction

  // Applies one accepted request to the shadow state and returns the result the
  // block must give for it. Fields that the request does not use stay zero.
  function automatic res_t advance_scan(req_t r);
    res_t        o;
    int unsigned sh;
    int unsigned avg;
    o = '0;
    if (r.action == ACTION_SAMPLE) begin
      sh = (shift_reg > MAX_SHIFT) ? MAX_SHIFT : shift_reg;
      sum_q += r.sample;
      taken++;
      if (taken >= (1 << sh)) begin
        // The sum can hold more samples than the shift divides out when the
        // shift was lowered part way through an average, so the value clips.
        avg = sum_q >> sh;
        if (avg > SAMPLE_MAX) avg = SAMPLE_MAX;
        // The average lands in the current slot even when the count has since
        // shrunk below it; the slot then wraps to zero.
        avg_table[slot_now] = SAMPLE_BITS'(avg);
        o.average_written = 1'b1;
        o.average_slot    = 3'(slot_now);
        o.average_value   = SAMPLE_BITS'(avg);
        sum_q    = 0;
        taken    = 0;
        slot_now = (slot_now + 1 < scan_width()) ? slot_now + 1 : 0;
      end
    end else if (r.read_slot < scan_width()) begin
      o.read_data = avg_table[r.read_slot];
    end
    // The mux code is always that of the slot after this request.
    o.mux_select = map_reg[MUX_W*slot_now +: MUX_W];
    return o;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic enqueue(logic act, int unsigned smp, int unsigned slot);
    req_t r;
    r.action    = act;
    r.sample    = SAMPLE_BITS'(smp);
    r.read_slot = 4'(slot);
    req_backlog.push_back(r);
  endtask

  // Waits until every queued request has gone out and every predicted result has
  // come back, then adds margin before it returns.
  task automatic wait_idle();
    do @(negedge clk);
    while (req_backlog.size() != 0 || req_valid || scan_results_ahead.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // One register write per rising edge; the shadow copy follows the same masking
  // as the block, so random upper data bits must be ignored.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CHANNEL_COUNT: count_reg = val[CNT_W-1:0];
      REG_CHANNEL_MAP:   map_reg   = val;
      REG_AVG_SHIFT:     shift_reg = val[SHIFT_W-1:0];
      default: ;
    endcase
  endtask

  // Reconfigures the block between phases, only once it has gone idle.
  task automatic configure(int unsigned count, logic [MAP_W-1:0] map, int unsigned shift);
    wait_idle();
    write_reg(REG_CHANNEL_COUNT, (CFG_DATA_W'($urandom) & ~32'hF) | CFG_DATA_W'(count));
    write_reg(REG_CHANNEL_MAP, map);
    write_reg(REG_AVG_SHIFT, (CFG_DATA_W'($urandom) & ~32'hF) | CFG_DATA_W'(shift));
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Driver: offers the next request whenever the slot is free and no gap is running.
  // A stalled request is held unchanged until the block takes it.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) begin
        scan_results_ahead.push_back(advance_scan(req_data));
      end
      if (!req_valid || !req_stall) begin
        if (gap_left > 0 || req_backlog.size() == 0) begin
          if (gap_left > 0) gap_left--;
          req_valid <= 1'b0;
        end else begin
          req_data  <= req_backlog.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // About a third of the bursts run straight into the next one.
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // drives the stall pattern of the receiving side.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (scan_results_ahead.size() == 0) begin
        $error("result with no request outstanding: %p", res_data);
        mismatches++;
      end else begin
        due_result = scan_results_ahead.pop_front();
        check_field("mux_select", due_result.mux_select, res_data.mux_select);
        check_field("average_written", due_result.average_written,
                    res_data.average_written);
        check_field("average_slot", due_result.average_slot, res_data.average_slot);
        check_field("average_value", due_result.average_value, res_data.average_value);
        check_field("read_data", due_result.read_data, res_data.read_data);
      end
      results_seen++;
    end

    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (!hold_done && results_seen > 200 && req_backlog.size() > 40) begin
      // One long hold while plenty of requests are still queued, so the output
      // stage fills and the block has to stall its input.
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       res_stall <= 1'b0;
        1:       res_stall <= ($urandom_range(0, 3) == 0);
        2:       res_stall <= (mode_left % 3 == 0);
        default: res_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned i;
    int unsigned count;
    int unsigned shift;
    logic [MAP_W-1:0] map;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: one slot, mux code zero, four samples per average.
    // A full-scale average, then reads inside and outside the scanned range.
    repeat (4) enqueue(ACTION_SAMPLE, 1023, 0);
    enqueue(ACTION_READ, 0, 0);
    enqueue(ACTION_READ, 0, 1);
    enqueue(ACTION_READ, 0, 15);

    // Three slots, one sample per average: the slot walks 0, 1, 2 and wraps.
    configure(3, 32'hFEDC_BA98, 0);
    enqueue(ACTION_SAMPLE, 0, 0);
    enqueue(ACTION_SAMPLE, 1023, 0);
    enqueue(ACTION_SAMPLE, 512, 0);
    enqueue(ACTION_SAMPLE, 1, 0);
    enqueue(ACTION_READ, 0, 0);
    enqueue(ACTION_READ, 0, 1);
    enqueue(ACTION_READ, 0, 2);
    enqueue(ACTION_READ, 0, 3);
    enqueue(ACTION_READ, 0, 8);

    // The scan now sits on slot 1. A count of zero acts as one slot, so the next
    // average still goes to slot 1 and the scan wraps to 0; slot 1 then reads 0.
    configure(0, 32'hFFFF_FFFF, 0);
    enqueue(ACTION_SAMPLE, 700, 0);
    enqueue(ACTION_READ, 0, 1);

    // Count and shift above their ranges act as eight slots and 256 samples.
    configure(15, 32'h0123_4567, 15);
    repeat (3) enqueue(ACTION_SAMPLE, 1023, 0);

    // Lowering the shift part way through an average makes the stored value clip.
    configure(NUM_SLOTS, 32'h7654_3210, 0);
    enqueue(ACTION_SAMPLE, 1023, 0);
    enqueue(ACTION_READ, 0, 0);

    // Random phases: the first ones hit the register extremes, later ones pick
    // settings at random with mostly short averages so results keep coming.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0:       count = 0;
        1:       count = 1;
        2:       count = NUM_SLOTS;
        3:       count = 15;
        default: count = $urandom_range(0, 15);
      endcase
      case (p)
        0:       map = '1;
        1:       map = '0;
        default: map = $urandom;
      endcase
      case (p)
        0:       shift = 0;
        4:       shift = MAX_SHIFT;
        5:       shift = 15;
        default: shift = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 15)
                                                     : $urandom_range(0, 3);
      endcase
      configure(count, map, shift);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        enqueue(($urandom_range(0, 3) == 0) ? ACTION_READ : ACTION_SAMPLE,
                ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(0, 1023),
                $urandom_range(0, 15));
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/asa_pkg.sv
design/adc_scan_averager.sv
tb/sv/adc_scan_averager_test.sv
